FILE: hw/rtl/csii_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cell set inverted index insert unit.
// No dependencies.
package csii_pkg;

	localparam int CELL_W    = 12;
	localparam int ID_W      = 32;
	localparam int CNT_W     = 32;
	localparam int OUT_POS_W = 10;
	localparam int STAT_W    = 2;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SET_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ENTRY_FULL = 2'd2;
	localparam logic [STAT_W-1:0] STAT_POST_FULL  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RED,
		ST_SCAN,
		ST_CHECK,
		ST_ELEN,
		ST_PSCAN,
		ST_PDEC,
		ST_COMMIT,
		ST_OUT
	} state_t;

endpackage

FILE: hw/rtl/csii_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module csii_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/cell_set_inverted_index_insert_unit.sv
`timescale 1ns / 1ps
// Top level of the cell set inverted index insert unit: control and datapath.
// Depends on csii_pkg and csii_ram.

// One item at a time. After reset the cell map is cleared, one entry per cycle,
// over all MAX_CELLS entries before the first input is taken. An item then
// reduces a cell number at or above MAX_CELLS by up to CELL_W compare-and-subtract
// steps, scans up to the S distinct sets stored (one set memory word per cycle)
// and, if the set is found, the cell's posting list (one posting memory word per
// cycle). The finished result sits in an output register, so the next item is
// taken while it waits.
module cell_set_inverted_index_insert_unit #(
	parameter int MAX_SETS           = 1024,
	parameter int MAX_CELLS          = 4096,
	parameter int MAX_ENTRIES        = 1024,
	parameter int MAX_SETS_PER_ENTRY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [csii_pkg::CELL_W-1:0]       cell_number,
	input  logic [csii_pkg::ID_W-1:0]         table_number,
	input  logic [csii_pkg::ID_W-1:0]         set_number,
	input  logic [csii_pkg::ID_W-1:0]         set_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [csii_pkg::OUT_POS_W-1:0]    set_position,
	output logic [csii_pkg::OUT_POS_W-1:0]    entry_position,
	output logic                              set_was_new,
	output logic                              entry_was_new,
	output logic [csii_pkg::CNT_W-1:0]        vectors_in_cell,
	output logic [csii_pkg::STAT_W-1:0]       status
);
	import csii_pkg::*;

	localparam int SP_W       = $clog2(MAX_SETS);
	localparam int ST_W       = $clog2(MAX_SETS + 1);
	localparam int EP_W       = $clog2(MAX_ENTRIES);
	localparam int ET_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CA_W       = $clog2(MAX_CELLS);
	localparam int LEN_W      = $clog2(MAX_SETS_PER_ENTRY + 1);
	localparam int POST_DEPTH = MAX_ENTRIES * MAX_SETS_PER_ENTRY;
	localparam int PA_W       = $clog2(POST_DEPTH);
	localparam int MAP_W      = EP_W + 1;
	localparam int ENT_W      = LEN_W + CELL_W;
	localparam int POST_W     = SP_W + CNT_W;
	localparam int SET_W      = 3 * ID_W;
	localparam int RK_W       = $clog2(CELL_W);
	localparam int RD_W       = CELL_W + CA_W + 1;

	state_t state_q, state_d;

	// memory ports
	logic              set_we, set_re;
	logic [SP_W-1:0]   set_waddr, set_raddr;
	logic [SET_W-1:0]  set_wdata, set_rdata;
	logic              map_we, map_re;
	logic [CA_W-1:0]   map_waddr, map_raddr;
	logic [MAP_W-1:0]  map_wdata, map_rdata;
	logic              ent_we, ent_re;
	logic [EP_W-1:0]   ent_waddr, ent_raddr;
	logic [ENT_W-1:0]  ent_wdata, ent_rdata;
	logic              post_we, post_re;
	logic [PA_W-1:0]   post_waddr, post_raddr;
	logic [POST_W-1:0] post_wdata, post_rdata;

	// control registers
	logic [CA_W-1:0]   clr_q;
	logic [ST_W-1:0]   set_total_q;
	logic [ET_W-1:0]   ent_total_q;
	logic [ST_W-1:0]   sidx_q;
	logic              spend_s1;
	logic [LEN_W-1:0]  pidx_q;
	logic              ppend_s1;
	logic              out_valid_q;
	logic [RK_W-1:0]   red_k_q;

	// payload registers
	logic [CELL_W-1:0] cell_q;
	logic [ID_W-1:0]   table_q, set_q, length_q;
	logic [SP_W-1:0]   sslot_s1;
	logic [LEN_W-1:0]  pslot_s1;
	logic              found_q, efound_q, slot_found_q;
	logic [SP_W-1:0]   spos_q;
	logic [EP_W-1:0]   epos_q;
	logic [LEN_W-1:0]  len_q, slot_q;
	logic [CELL_W-1:0] ecell_q;
	logic [PA_W-1:0]   base_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OUT_POS_W-1:0] res_spos_q, res_epos_q;
	logic              res_snew_q, res_enew_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [OUT_POS_W-1:0] o_spos_q, o_epos_q;
	logic              o_snew_q, o_enew_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic [STAT_W-1:0] o_stat_q;

	logic              in_fire, out_load;
	logic              shit, phit, need_red, set_full, ent_full, entry_found;
	logic [CNT_W-1:0]  cnt_inc;
	logic [PA_W-1:0]   new_base;
	logic [RD_W-1:0]   red_div;

	csii_ram #(.WIDTH(SET_W), .DEPTH(MAX_SETS)) u_set_mem (
		.clk(clk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
		.re(set_re), .raddr(set_raddr), .rdata(set_rdata));

	csii_ram #(.WIDTH(MAP_W), .DEPTH(MAX_CELLS)) u_map_mem (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.re(map_re), .raddr(map_raddr), .rdata(map_rdata));

	csii_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_ent_mem (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata));

	csii_ram #(.WIDTH(POST_W), .DEPTH(POST_DEPTH)) u_post_mem (
		.clk(clk), .we(post_we), .waddr(post_waddr), .wdata(post_wdata),
		.re(post_re), .raddr(post_raddr), .rdata(post_rdata));

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// restoring reduction: MAX_CELLS shifted left by the current step
	assign red_div     = RD_W'(MAX_CELLS) << red_k_q;
	assign need_red    = RD_W'(cell_q) >= RD_W'(MAX_CELLS);
	assign shit        = spend_s1 && (set_rdata[SET_W-1:ID_W] == {table_q, set_q});
	assign phit        = ppend_s1 && (post_rdata[POST_W-1:CNT_W] == spos_q);
	assign entry_found = map_rdata[EP_W];
	assign set_full    = !found_q && (set_total_q == ST_W'(MAX_SETS));
	assign ent_full    = !entry_found && (ent_total_q == ET_W'(MAX_ENTRIES));
	assign cnt_inc     = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);
	assign new_base    = PA_W'(epos_q) * PA_W'(MAX_SETS_PER_ENTRY);

	always_comb begin
		state_d    = state_q;
		set_we     = 1'b0;
		set_waddr  = SP_W'(set_total_q);
		set_wdata  = {table_q, set_q, length_q};
		set_re     = 1'b0;
		set_raddr  = sidx_q[SP_W-1:0];
		map_we     = 1'b0;
		map_waddr  = CA_W'(cell_q);
		map_wdata  = {1'b1, epos_q};
		map_re     = 1'b0;
		map_raddr  = CA_W'(cell_q);
		ent_we     = 1'b0;
		ent_waddr  = epos_q;
		ent_wdata  = {LEN_W'(1), cell_q};
		ent_re     = 1'b0;
		ent_raddr  = map_rdata[EP_W-1:0];
		post_we    = 1'b0;
		post_waddr = new_base;
		post_wdata = {spos_q, CNT_W'(1)};
		post_re    = 1'b0;
		post_raddr = base_q + PA_W'(pidx_q);
		case (state_q)
			ST_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
				if (clr_q == CA_W'(MAX_CELLS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire)
					state_d = ST_RED;
			end
			ST_RED: begin
				if (!need_red) begin
					map_re  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				set_re = (sidx_q < set_total_q) && !shit;
				if (shit || (!spend_s1 && sidx_q >= set_total_q))
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (set_full || ent_full)
					state_d = ST_OUT;
				else if (entry_found) begin
					ent_re  = 1'b1;
					state_d = ST_ELEN;
				end else
					state_d = ST_COMMIT;
			end
			ST_ELEN: begin
				state_d = found_q ? ST_PSCAN : ST_PDEC;
			end
			ST_PSCAN: begin
				post_re = (pidx_q < len_q) && !phit;
				if (phit || (!ppend_s1 && pidx_q >= len_q))
					state_d = ST_PDEC;
			end
			ST_PDEC: begin
				if (!slot_found_q && len_q == LEN_W'(MAX_SETS_PER_ENTRY))
					state_d = ST_OUT;
				else
					state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				set_we = !found_q;
				if (!efound_q) begin
					map_we  = 1'b1;
					ent_we  = 1'b1;
					post_we = 1'b1;
				end else if (slot_found_q) begin
					post_we    = 1'b1;
					post_waddr = base_q + PA_W'(slot_q);
					post_wdata = {spos_q, cnt_inc};
				end else begin
					post_we    = 1'b1;
					post_waddr = base_q + PA_W'(len_q);
					ent_we     = 1'b1;
					ent_wdata  = {len_q + LEN_W'(1), ecell_q};
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			set_total_q <= '0;
			ent_total_q <= '0;
			sidx_q      <= '0;
			spend_s1    <= 1'b0;
			pidx_q      <= '0;
			ppend_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + CA_W'(1);
			if (state_q == ST_RED) begin
				sidx_q   <= '0;
				spend_s1 <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				spend_s1 <= set_re;
				if (set_re)
					sidx_q <= sidx_q + ST_W'(1);
			end
			if (state_q == ST_ELEN) begin
				pidx_q   <= '0;
				ppend_s1 <= 1'b0;
			end
			if (state_q == ST_PSCAN) begin
				ppend_s1 <= post_re;
				if (post_re)
					pidx_q <= pidx_q + LEN_W'(1);
			end
			if (state_q == ST_COMMIT) begin
				if (!found_q)
					set_total_q <= set_total_q + ST_W'(1);
				if (!efound_q)
					ent_total_q <= ent_total_q + ET_W'(1);
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cell_q   <= cell_number;
			table_q  <= table_number;
			set_q    <= set_number;
			length_q <= set_length;
			found_q  <= 1'b0;
			red_k_q  <= RK_W'(CELL_W - 1);
		end
		if (state_q == ST_RED && need_red) begin
			if (RD_W'(cell_q) >= red_div)
				cell_q <= cell_q - red_div[CELL_W-1:0];
			red_k_q <= red_k_q - RK_W'(1);
		end
		if (state_q == ST_SCAN) begin
			sslot_s1 <= sidx_q[SP_W-1:0];
			if (shit) begin
				found_q <= 1'b1;
				spos_q  <= sslot_s1;
			end
		end
		if (state_q == ST_CHECK) begin
			if (!found_q)
				spos_q <= SP_W'(set_total_q);
			efound_q     <= entry_found;
			epos_q       <= entry_found ? map_rdata[EP_W-1:0] : EP_W'(ent_total_q);
			slot_found_q <= 1'b0;
			res_spos_q   <= '0;
			res_epos_q   <= '0;
			res_snew_q   <= 1'b0;
			res_enew_q   <= 1'b0;
			res_cnt_q    <= '0;
			res_stat_q   <= set_full ? STAT_SET_FULL : STAT_ENTRY_FULL;
		end
		if (state_q == ST_ELEN) begin
			len_q   <= ent_rdata[ENT_W-1:CELL_W];
			ecell_q <= ent_rdata[CELL_W-1:0];
			base_q  <= new_base;
		end
		if (state_q == ST_PSCAN) begin
			pslot_s1 <= pidx_q;
			if (phit) begin
				slot_found_q <= 1'b1;
				slot_q       <= pslot_s1;
				cnt_q        <= post_rdata[CNT_W-1:0];
			end
		end
		if (state_q == ST_PDEC)
			res_stat_q <= STAT_POST_FULL;
		if (state_q == ST_COMMIT) begin
			res_spos_q <= OUT_POS_W'(spos_q);
			res_epos_q <= OUT_POS_W'(epos_q);
			res_snew_q <= !found_q;
			res_enew_q <= !efound_q;
			res_cnt_q  <= (efound_q && slot_found_q) ? cnt_inc : CNT_W'(1);
			res_stat_q <= STAT_OK;
		end
		if (out_load) begin
			o_spos_q <= res_spos_q;
			o_epos_q <= res_epos_q;
			o_snew_q <= res_snew_q;
			o_enew_q <= res_enew_q;
			o_cnt_q  <= res_cnt_q;
			o_stat_q <= res_stat_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign set_position    = o_spos_q;
	assign entry_position  = o_epos_q;
	assign set_was_new     = o_snew_q;
	assign entry_was_new   = o_enew_q;
	assign vectors_in_cell = o_cnt_q;
	assign status          = o_stat_q;

endmodule

FILE: tb/cell_set_inverted_index_insert_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cell_set_inverted_index_insert_unit.
// Uses csii_pkg and the unit's RTL; holds its own index predictor and random stimulus.
module cell_set_inverted_index_insert_unit_tb;
	import csii_pkg::*;

	localparam int N_SETS    = 1024;
	localparam int N_ENTRIES = 1024;
	localparam int N_POST    = 16;
	localparam int CYCLE_LIMIT = 8000000;

	typedef struct {
		logic [CELL_W-1:0] cnum;
		logic [ID_W-1:0]   tbl;
		logic [ID_W-1:0]   setn;
		logic [ID_W-1:0]   len;
	} vec_item_t;

	typedef struct {
		logic [OUT_POS_W-1:0] spos;
		logic [OUT_POS_W-1:0] epos;
		logic                 snew;
		logic                 enew;
		logic [CNT_W-1:0]     cnt;
		logic [STAT_W-1:0]    stat;
	} insert_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [CELL_W-1:0] cell_number;
	logic [ID_W-1:0] table_number, set_number, set_length;
	logic [OUT_POS_W-1:0] set_position, entry_position;
	logic set_was_new, entry_was_new;
	logic [CNT_W-1:0] vectors_in_cell;
	logic [STAT_W-1:0] status;

	cell_set_inverted_index_insert_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cell_number(cell_number), .table_number(table_number),
		.set_number(set_number), .set_length(set_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.set_position(set_position), .entry_position(entry_position),
		.set_was_new(set_was_new), .entry_was_new(entry_was_new),
		.vectors_in_cell(vectors_in_cell), .status(status)
	);

	vec_item_t pending_vecs[$];
	insert_result_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int in_gap = 0, out_gap = 0;

	// index model
	int pair_pos[logic [63:0]];
	int pair_total = 0;
	int cell_map_model[int];
	int entry_total = 0;
	int post_len[N_ENTRIES];
	logic [OUT_POS_W-1:0] post_set[N_ENTRIES][N_POST];
	logic [CNT_W-1:0] post_cnt[N_ENTRIES][N_POST];

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic predict_insert(input vec_item_t it);
		insert_result_t r;
		logic [63:0] key;
		bit set_found, entry_found, slot_found;
		int spos, epos, slot, c;
		r = '{default: '0};
		key = {it.tbl, it.setn};
		c = int'(it.cnum);
		set_found = pair_pos.exists(key);
		spos = set_found ? pair_pos[key] : pair_total;
		entry_found = cell_map_model.exists(c);
		epos = entry_found ? cell_map_model[c] : entry_total;
		slot_found = 0;
		slot = 0;
		if (entry_found && set_found)
			for (int i = 0; i < post_len[epos]; i++)
				if (!slot_found && post_set[epos][i] == OUT_POS_W'(spos)) begin
					slot_found = 1;
					slot = i;
				end
		if (!set_found && pair_total >= N_SETS) begin
			r.stat = STAT_SET_FULL;
		end else if (!entry_found && entry_total >= N_ENTRIES) begin
			r.stat = STAT_ENTRY_FULL;
		end else if (entry_found && !slot_found && post_len[epos] >= N_POST) begin
			r.stat = STAT_POST_FULL;
		end else begin
			r.stat = STAT_OK;
			if (!set_found) begin
				pair_pos[key] = pair_total;
				pair_total++;
			end
			if (!entry_found) begin
				cell_map_model[c] = epos;
				entry_total++;
				post_len[epos] = 0;
			end
			if (slot_found) begin
				if (post_cnt[epos][slot] != '1)
					post_cnt[epos][slot]++;
			end else begin
				slot = post_len[epos];
				post_set[epos][slot] = OUT_POS_W'(spos);
				post_cnt[epos][slot] = CNT_W'(1);
				post_len[epos]++;
			end
			r.spos = OUT_POS_W'(spos);
			r.epos = OUT_POS_W'(epos);
			r.snew = !set_found;
			r.enew = !entry_found;
			r.cnt = post_cnt[epos][slot];
		end
		expected_results.push_back(r);
	endtask

	task automatic add_vec(input int cnum, input logic [31:0] t, input logic [31:0] s,
			input logic [31:0] l);
		vec_item_t it;
		it.cnum = CELL_W'(cnum);
		it.tbl = t;
		it.setn = s;
		it.len = l;
		pending_vecs.push_back(it);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cell_number <= '0;
			table_number <= '0;
			set_number <= '0;
			set_length <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_insert('{cell_number, table_number, set_number, set_length});
				in_gap = pick_gap();
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0 || pending_vecs.size() == 0) begin
					if (in_gap > 0) in_gap--;
					in_valid <= 1'b0;
				end else begin
					vec_item_t it;
					it = pending_vecs.pop_front();
					cell_number <= it.cnum;
					table_number <= it.tbl;
					set_number <= it.setn;
					set_length <= it.len;
					in_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				insert_result_t e;
				if (expected_results.size() == 0) begin
					report("unexpected transfer", '0, '0);
				end else begin
					e = expected_results.pop_front();
					if (set_position !== e.spos)
						report("set_position", 64'(set_position), 64'(e.spos));
					if (entry_position !== e.epos)
						report("entry_position", 64'(entry_position), 64'(e.epos));
					if (set_was_new !== e.snew)
						report("set_was_new", 64'(set_was_new), 64'(e.snew));
					if (entry_was_new !== e.enew)
						report("entry_was_new", 64'(entry_was_new), 64'(e.enew));
					if (vectors_in_cell !== e.cnt)
						report("vectors_in_cell", 64'(vectors_in_cell), 64'(e.cnt));
					if (status !== e.stat)
						report("status", 64'(status), 64'(e.stat));
				end
				out_gap = pick_gap();
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		// directed: field extremes, repeat count, posting list overflow
		add_vec(0, 0, 0, 0);
		add_vec(0, 0, 0, 0);
		add_vec(4095, '1, '1, '1);
		add_vec(0, '1, '1, 32'h1234);
		for (int k = 0; k < 16; k++)
			add_vec(7, 1, k, k);
		add_vec(7, 1, 16, 5);
		add_vec(7, 1, 3, 9);
		add_vec(4095, 0, 0, '1);
		// random, mostly from a small pool so pairs and cells repeat
		for (int k = 0; k < 550; k++) begin
			if ($urandom_range(0, 99) < 80)
				add_vec($urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 15),
					$urandom);
			else
				add_vec($urandom_range(0, 4095), $urandom, $urandom, $urandom);
		end
		repeat (7) @(posedge clk);
		arst_n = 1'b1;
		while (pending_vecs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: cell_set_inverted_index_insert_unit.f
hw/rtl/csii_pkg.sv
hw/rtl/csii_ram.sv
hw/rtl/cell_set_inverted_index_insert_unit.sv
tb/cell_set_inverted_index_insert_unit_tb.sv
